// ===== src/assert_macros.svh =====
// Assertion helper macros for the go-to-goal block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every edge, off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== src/gtg_pkg.sv =====
// ----------------------------------------------------------------------------
// gtg_pkg
// Types, constants and tables shared by the go-to-goal controller.
// ----------------------------------------------------------------------------
package gtg_pkg;
	localparam int CordicStepsDef = 16;
	localparam int TableLen       = 24;
	localparam int ZW             = 20;
	localparam int CW             = 30;
	localparam logic signed [ZW-1:0] PiQ16 = 20'sd205887;
	localparam logic signed [17:0] PiQ12 = 18'sd12868;
	localparam logic signed [17:0] TwoPiQ12 = 18'sd25736;
	localparam logic [19:0] InvGainQ20 = 20'd636751;

	typedef enum logic [1:0] {
		ACT_POSE = 2'd0,
		ACT_CAND = 2'd1,
		ACT_TICK = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_SELECT_NEAREST = 2'd0,
		REG_REACH_RADIUS   = 2'd1,
		REG_LINEAR_GAIN    = 2'd2,
		REG_ANGULAR_GAIN   = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_INIT, ST_ITER, ST_DIST, ST_MUL, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} cordic_ctl_t;

	function automatic logic [16:0] atan_lut(input logic [4:0] i);
		logic [16:0] r;
		case (i)
			5'd0: r = 17'd51472;  5'd1: r = 17'd30386; 5'd2: r = 17'd16055;
			5'd3: r = 17'd8150;   5'd4: r = 17'd4091;  5'd5: r = 17'd2047;
			5'd6: r = 17'd1024;   5'd7: r = 17'd512;   5'd8: r = 17'd256;
			5'd9: r = 17'd128;    5'd10: r = 17'd64;   5'd11: r = 17'd32;
			5'd12: r = 17'd16;    5'd13: r = 17'd8;    5'd14: r = 17'd4;
			5'd15: r = 17'd2;     5'd16: r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction
endpackage

// ===== src/go_to_goal_nearest_target.sv =====
// ----------------------------------------------------------------------------
// go_to_goal_nearest_target
// Proportional go-to-goal controller chasing the nearest target.
// ----------------------------------------------------------------------------
// Pose and candidate transactions complete when accepted (the squared-distance
// compare is combinational, using two 17x17 products). A control tick steps
// through the iterative CORDIC, which runs one micro-rotation a cycle and then
// raises its done flag, followed by the distance scaling multiply and the gain
// multiplies. in_stall is high while a tick is in work or its result waits in
// the output register, so the next transaction is accepted only once the result
// has left the output register.
module go_to_goal_nearest_target import gtg_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [14:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [14:0] heading,
	input  logic [7:0]         target_id,
	input  logic               first_candidate,
	input  logic               last_candidate,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [16:0]        linear_speed,
	output logic signed [15:0] angular_speed,
	output logic               caught,
	output logic [7:0]         caught_id
);
	logic sel_q; logic [14:0] rad_q; logic [11:0] lg_q, ag_q;
	logic signed [15:0] rx_q, ry_q, gx_q, gy_q, bx_q, by_q;
	logic signed [14:0] rh_q;
	logic pv_q, gv_q, lo_q;
	logic [7:0] gid_q, bid_q;
	logic [33:0] bd_q;
	state_t st_q, st_d;
	cordic_ctl_t cctl;
	logic signed [CW-1:0] mag;
	logic signed [ZW-1:0] ang;
	logic signed [16:0] cdx, cdy;
	logic [49:0] dprod_s1;
	logic [31:0] dist_q;
	logic signed [17:0] err_q;
	logic [43:0] lin_s2;
	logic signed [31:0] angp_s2;
	logic acc, is_cand, first;
	logic [33:0] dsq;
	logic signed [16:0] ddx, ddy;
	logic signed [17:0] bear, e0;
	logic [44:0] lin_r;
	logic signed [31:0] ang_r;

	assign in_stall = (st_q != ST_IDLE) || out_valid;
	assign acc = in_valid && !in_stall;
	assign is_cand = acc && action_t'(action) == ACT_CAND;
	assign ddx = 17'(pos_x) - 17'(rx_q);
	assign ddy = 17'(pos_y) - 17'(ry_q);
	assign dsq = 34'(ddx) * 34'(ddx) + 34'(ddy) * 34'(ddy);
	assign first = first_candidate || !lo_q;
	assign cdx = 17'(gx_q) - 17'(rx_q);
	assign cdy = 17'(gy_q) - 17'(ry_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b1; rad_q <= 15'd512; lg_q <= 12'd512; ag_q <= 12'd512;
			rx_q <= '0; ry_q <= '0; rh_q <= '0; pv_q <= 1'b0; gv_q <= 1'b0;
			gx_q <= '0; gy_q <= '0; gid_q <= '0; bx_q <= '0; by_q <= '0;
			bid_q <= '0; bd_q <= '0; lo_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_SELECT_NEAREST: sel_q <= cfg_data[0];
					REG_REACH_RADIUS:   rad_q <= cfg_data;
					REG_LINEAR_GAIN:    lg_q <= cfg_data[11:0];
					REG_ANGULAR_GAIN:   ag_q <= cfg_data[11:0];
				endcase
			end
			if (acc && action_t'(action) == ACT_POSE) begin
				rx_q <= pos_x; ry_q <= pos_y; rh_q <= heading; pv_q <= 1'b1;
			end
			if (is_cand) begin
				if (first || (sel_q && dsq < bd_q)) begin
					bx_q <= pos_x; by_q <= pos_y; bid_q <= target_id; bd_q <= dsq;
				end
				if (first && !last_candidate) lo_q <= 1'b1;
				if (last_candidate) begin
					if (first || (sel_q && dsq < bd_q)) begin
						gx_q <= pos_x; gy_q <= pos_y; gid_q <= target_id;
					end else begin
						gx_q <= bx_q; gy_q <= by_q; gid_q <= bid_q;
					end
					gv_q <= 1'b1; lo_q <= 1'b0;
				end
			end
			if (st_q == ST_OUT && !(dist_q > 32'(rad_q))) gv_q <= 1'b0;
		end
	end

	gtg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .start(st_q == ST_INIT), .dx(cdx), .dy(cdy),
		.ctl(cctl), .mag, .ang
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (acc && action_t'(action) == ACT_TICK && pv_q && gv_q) st_d = ST_INIT;
			ST_INIT: st_d = ST_ITER;
			ST_ITER: if (cctl.done) st_d = ST_DIST;
			ST_DIST: st_d = ST_MUL;
			ST_MUL:  st_d = ST_OUT;
			ST_OUT:  st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	assign bear = 18'((ang + ZW'(8)) >>> 4);
	assign e0 = bear - 18'(rh_q);
	assign lin_r = 45'(lin_s2) + 45'd128;
	assign ang_r = angp_s2 + 32'sd128;

	always_ff @(posedge clk) begin
		if (cctl.done) dprod_s1 <= 50'(mag[28:0]) * 50'(InvGainQ20) + 50'd134217728;
		if (st_q == ST_DIST) begin
			dist_q <= 32'(dprod_s1 >> 28);
			if (e0 > PiQ12) err_q <= e0 - TwoPiQ12;
			else if (e0 < -PiQ12) err_q <= e0 + TwoPiQ12;
			else err_q <= e0;
		end
		if (st_q == ST_MUL) begin
			lin_s2  <= 44'(lg_q) * 44'(dist_q);
			angp_s2 <= $signed({1'b0, ag_q}) * err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (st_q == ST_OUT) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_OUT) begin
			if (dist_q > 32'(rad_q)) begin
				linear_speed <= (lin_r[44:8] > 37'd131071) ? 17'd131071 : lin_r[24:8];
				if ((ang_r >>> 8) > 32'sd32767) angular_speed <= 16'sd32767;
				else if ((ang_r >>> 8) < -32'sd32768) angular_speed <= -16'sd32768;
				else angular_speed <= ang_r[23:8];
				caught <= 1'b0; caught_id <= '0;
			end else begin
				linear_speed <= '0; angular_speed <= '0;
				caught <= 1'b1; caught_id <= gid_q;
			end
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_stall_busy, st_q != ST_IDLE, in_stall, "input taken mid tick")
	`ASSERT_NEXT(a_out_after, st_q == ST_OUT, out_valid, "result lost")
	`ASSERT_IMPL(a_goal_tick, st_q == ST_INIT, gv_q && pv_q, "tick without goal")
endmodule

// ===== src/gtg_cordic.sv =====
// ----------------------------------------------------------------------------
// gtg_cordic
// Iterative vectoring CORDIC: one micro-rotation per cycle on a shared
// add/shift datapath, giving magnitude (gain-scaled) and angle in Q.16.
// ----------------------------------------------------------------------------
module gtg_cordic import gtg_pkg::*; #(
	parameter int CORDIC_STEPS = CordicStepsDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [16:0]   dx,
	input  logic signed [16:0]   dy,
	output cordic_ctl_t          ctl,
	output logic signed [CW-1:0] mag,
	output logic signed [ZW-1:0] ang
);
	localparam int IW = $clog2(CORDIC_STEPS + 1);
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [IW-1:0] i_q;
	logic busy_q, done_q;
	logic signed [CW-1:0] xs, ys;
	logic signed [ZW-1:0] at;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = ZW'(signed'({1'b0, atan_lut(5'(i_q))}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == IW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (dx < 0) begin
				x_q <= -(CW'(dx) <<< 8);
				y_q <= -(CW'(dy) <<< 8);
				z_q <= (dy >= 0) ? PiQ16 : -PiQ16;
			end else begin
				x_q <= CW'(dx) <<< 8;
				y_q <= CW'(dy) <<< 8;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - at;
			end
		end
	end

	assign ctl = '{start: start, busy: busy_q, done: done_q};
	assign mag = x_q;
	assign ang = z_q;

	`include "assert_macros.svh"
	`ASSERT_NEXT(a_done_once, done_q, !done_q, "CORDIC done held two cycles")
	`ASSERT_IMPL(a_done_idle, done_q, !busy_q, "CORDIC done while busy")
	`ASSERT_IMPL(a_mag_pos, busy_q && i_q > 0, x_q >= 0, "CORDIC magnitude negative")
endmodule
